// File: rtl/core/grid_astar_path_search_top_assert.svh
// Assertion macros for the grid A* search block
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_ASSERT_SVH
`define GA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define GA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/core/gastar_pkg.sv
// Types, constants and state codes for the grid A* search block
package gastar_pkg;
  localparam int MAX_NODES_DEF = 64;
  localparam logic [23:0] COST_MAX = 24'hFFFFFF;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEIGHBOR = 1'b1;

  localparam logic [2:0] K_EXPAND = 3'd0;
  localparam logic [2:0] K_PSTART = 3'd1;
  localparam logic [2:0] K_PSTEP  = 3'd2;
  localparam logic [2:0] K_NOPATH = 3'd3;
  localparam logic [2:0] K_BADCST = 3'd4;
  localparam logic [2:0] K_FULL   = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]       edge_cost;
    logic [7:0]        traversal_tag;
    logic [15:0]       move_inputs;
    logic              neighbor_valid;
    logic              last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]        out_traversal;
    logic [15:0]       out_inputs;
    logic              path_last;
    logic [15:0]       expanded_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_FIND_RD, S_FIND, S_INS, S_SEL_RD, S_SEL, S_SEL_CHK,
    S_CHAIN_RD, S_CHAIN, S_EMIT_RD, S_EMIT, S_HEUR
  } state_t;

  // node record: cell(32) cost(24) est(24) parent(6) tags(24) flags(2)
  localparam int NODE_W = 112;
endpackage

// File: rtl/core/gastar_ram.sv
// Generic single-port-write, one-read RAM with registered read
module gastar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/grid_astar_path_search_top.sv
// Top level of the grid A* search block: sequencer over a node RAM
// Start item: writes the start node, then runs the same selection as a list end.
// Neighbor item: scans the table entries up to the match or the last one, then inserts; a list end
// then adds a selection pass over all N nodes in the table before its result.
// Path: walks the parent links first, then emits the steps from the chain RAM;
// results cannot stall. Reset: idle, table empty.
module grid_astar_path_search_top #(
  parameter int MAX_NODES = gastar_pkg::MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  gastar_pkg::in_item_t   in_item,
  output logic                   result_valid,
  output gastar_pkg::out_item_t  result,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata
);
  import gastar_pkg::*;
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  state_t state, state_next;
  logic hmode;
  logic [CW-1:0] node_count;
  logic [AW-1:0] idx, cur, best, walk;
  logic best_ok, found;
  logic [23:0] best_est, cur_cost, next_cost;
  logic [31:0] goal_cell, nb_cell;
  logic [23:0] nb_tags;
  logic [15:0] expand_counter;
  logic last_flag;
  logic [CW-1:0] chain_n;
  logic [NODE_W-1:0] rd, wd;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [16:0] dx, dy;
  logic c_we;
  logic [AW-1:0] c_raddr, c_rd;

  wire [31:0] r_cell = rd[111:80];
  wire [23:0] r_cost = rd[79:56];
  wire [23:0] r_est = rd[55:32];
  wire [5:0]  r_par = rd[31:26];
  wire [23:0] r_tags = rd[25:2];
  wire [1:0]  r_flags = rd[1:0];

  gastar_ram #(.WIDTH(NODE_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rd)
  );

  // parent chain of the path, goal first
  gastar_ram #(.WIDTH(AW), .DEPTH(1 << AW)) u_chain (
    .clk(clk), .we(c_we), .waddr(chain_n[AW-1:0]), .wdata(walk), .raddr(c_raddr),
    .rdata(c_rd)
  );

  wire accept = start && !busy;
  assign busy = !(state == S_IDLE || state == S_WAIT);
  wire [CW-1:0] idx_w = CW'(idx);
  wire last_idx = (idx_w + 1'b1) >= node_count;

  // shared adder: heuristic (Manhattan) plus saturating add
  always_comb begin
    dx = {nb_cell[31], nb_cell[31:16]} - {goal_cell[31], goal_cell[31:16]};
    dy = {nb_cell[15], nb_cell[15:0]} - {goal_cell[15], goal_cell[15:0]};
    if (dx[16]) dx = -dx;
    if (dy[16]) dy = -dy;
  end
  logic [24:0] sum;
  assign sum = {1'b0, next_cost} + (hmode ? 25'(dx) + 25'(dy) : 25'd0);

  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE, S_WAIT: begin
        if (accept) begin
          if (in_item.req_type == REQ_START) state_next = S_HEUR;
          else if (state == S_WAIT) begin
            if (!in_item.neighbor_valid) state_next = S_SEL_RD;
            else if (in_item.edge_cost == '0) state_next = S_IDLE;
            else state_next = S_FIND_RD;
          end
        end
      end
      S_HEUR: state_next = S_SEL_RD;
      S_FIND_RD: state_next = S_FIND;
      S_FIND: begin
        if (r_cell == nb_cell || last_idx) state_next = S_INS;
        else state_next = S_FIND_RD;
      end
      S_INS: begin
        if (!found && node_count >= CW'(MAX_NODES)) state_next = S_IDLE;
        else if (last_flag) state_next = S_SEL_RD;
        else state_next = S_WAIT;
      end
      S_SEL_RD: state_next = S_SEL;
      S_SEL: state_next = last_idx ? S_SEL_CHK : S_SEL_RD;
      S_SEL_CHK: state_next = S_CHAIN_RD;
      S_CHAIN_RD: state_next = S_CHAIN;
      S_CHAIN: begin
        if (!best_ok) state_next = S_IDLE;
        else if (r_cell != goal_cell && chain_n == '0) state_next = S_WAIT;
        else if (r_flags[1] && chain_n < CW'(MAX_NODES - 1)) state_next = S_CHAIN_RD;
        else state_next = S_EMIT_RD;
      end
      S_EMIT_RD: state_next = S_EMIT;
      S_EMIT: state_next = (chain_n == '0) ? S_IDLE : S_EMIT_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    raddr = idx;
    if (state == S_CHAIN_RD || state == S_CHAIN) raddr = walk;
    if (state == S_EMIT_RD) raddr = c_rd;
    c_raddr = (state == S_EMIT) ? AW'(chain_n - 2'd2) : AW'(chain_n - 1'b1);
    c_we = (state == S_CHAIN) && best_ok && !(r_cell != goal_cell && chain_n == '0) &&
           r_flags[1] && (chain_n < CW'(MAX_NODES - 1));
    we = 1'b0;
    waddr = idx;
    wd = rd;
    if (state == S_HEUR) begin
      we = 1'b1;
      waddr = '0;
      wd = {nb_cell, 24'd0, sum[24] ? COST_MAX : sum[23:0], 6'd0, 24'd0, 2'b00};
    end else if (state == S_INS && (found ? (next_cost < r_cost)
                                          : (node_count < CW'(MAX_NODES)))) begin
      we = 1'b1;
      waddr = found ? idx : AW'(node_count);
      wd = {nb_cell, next_cost, sum[24] ? COST_MAX : sum[23:0],
            6'(cur), nb_tags, 2'b10};
    end else if (state == S_CHAIN && best_ok && chain_n == '0 && r_cell != goal_cell) begin
      we = 1'b1;
      waddr = walk;
      wd = {rd[111:2], r_flags | 2'b01};
    end
  end

  logic [24:0] cs;
  assign cs = {1'b0, cur_cost} + {9'd0, in_item.edge_cost};

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      hmode <= 1'b0;
      node_count <= '0;
      expand_counter <= '0;
      goal_cell <= '0;
      cur <= '0;
      idx <= '0;
      chain_n <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) hmode <= cfg_wdata;
      unique case (state) inside
        S_IDLE, S_WAIT: if (accept) begin
          nb_cell <= {in_item.cell_x, in_item.cell_y};
          nb_tags <= {in_item.traversal_tag, in_item.move_inputs};
          last_flag <= in_item.last_neighbor;
          idx <= '0;
          best_ok <= 1'b0;
          found <= 1'b0;
          next_cost <= cs[24] ? COST_MAX : (cs > 25'(COST_MAX) ? COST_MAX : cs[23:0]);
          if (in_item.req_type == REQ_START) begin
            goal_cell <= {in_item.goal_x, in_item.goal_y};
            node_count <= CW'(1);
            expand_counter <= '0;
            cur <= '0;
            next_cost <= '0;
          end else if (state == S_WAIT && in_item.neighbor_valid &&
                       in_item.edge_cost == '0) begin
            result_valid <= 1'b1;
            result <= '{K_BADCST, '0, '0, '0, '0, 1'b1, expand_counter};
          end
        end
        S_FIND: begin
          if (r_cell == nb_cell) found <= 1'b1;
          else if (!last_idx) idx <= idx + 1'b1;
        end
        S_INS: begin
          idx <= '0;
          best_ok <= 1'b0;
          if (!found) begin
            if (node_count >= CW'(MAX_NODES)) begin
              result_valid <= 1'b1;
              result <= '{K_FULL, '0, '0, '0, '0, 1'b1, expand_counter};
            end else node_count <= node_count + 1'b1;
          end
        end
        S_HEUR: idx <= '0;
        S_SEL: begin
          if (!r_flags[0] && (!best_ok || r_est < best_est)) begin
            best_ok <= 1'b1;
            best <= idx;
            best_est <= r_est;
          end
          if (!last_idx) idx <= idx + 1'b1;
        end
        S_SEL_CHK: begin
          walk <= best;
          chain_n <= '0;
          if (!best_ok) begin
            result_valid <= 1'b1;
            result <= '{K_NOPATH, '0, '0, '0, '0, 1'b1, expand_counter};
          end
        end
        S_CHAIN: if (best_ok) begin
          if (r_cell != goal_cell && chain_n == '0) begin
            cur <= walk;
            cur_cost <= r_cost;
            if (expand_counter != 16'hFFFF) begin
              expand_counter <= expand_counter + 1'b1;
              result <= '{K_EXPAND, r_cell[31:16], r_cell[15:0], '0, '0, 1'b1,
                          expand_counter + 1'b1};
            end else
              result <= '{K_EXPAND, r_cell[31:16], r_cell[15:0], '0, '0, 1'b1,
                          expand_counter};
            result_valid <= 1'b1;
          end else if (r_flags[1] && chain_n < CW'(MAX_NODES - 1)) begin
            chain_n <= chain_n + 1'b1;
            walk <= AW'(r_par);
          end else begin
            result_valid <= 1'b1;
            result <= '{K_PSTART, r_cell[31:16], r_cell[15:0], '0, '0,
                        chain_n == '0, expand_counter};
          end
        end
        S_EMIT: if (chain_n != '0) begin
          result_valid <= 1'b1;
          result <= '{K_PSTEP, r_cell[31:16], r_cell[15:0], r_tags[23:16], r_tags[15:0],
                      chain_n == CW'(1), expand_counter};
          chain_n <= chain_n - 1'b1;
        end
        default: ;
      endcase
    end
  end

  `include "grid_astar_path_search_top_assert.svh"
  `GA_ASSERT_IMPL(a_cnt_bound, 1'b1, node_count <= CW'(MAX_NODES))
  `GA_ASSERT_NEXT(a_busy_after_start, accept && in_item.req_type == REQ_START, busy)
  `GA_ASSERT_IMPL(a_valid_kind, result_valid, result.result_kind <= K_FULL)
endmodule

// File: verif/tb_grid_astar_path_search_top.sv
// Testbench for grid_astar_path_search_top: predicted-result scoreboard, directed and random searches
`timescale 1ns / 100ps

module tb_grid_astar_path_search_top;
  import gastar_pkg::*;

  localparam int SLOTS = 64;
  localparam int SETTLE = 400;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic result_valid;
  out_item_t result;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  grid_astar_path_search_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // search state mirror
  logic [31:0] nd_cell [SLOTS];
  logic [23:0] nd_cost [SLOTS];
  logic [23:0] nd_est [SLOTS];
  logic [5:0] nd_par [SLOTS];
  logic [23:0] nd_tags [SLOTS];
  logic [1:0] nd_flg [SLOTS];
  int unsigned nd_cnt = 0;
  bit searching = 1'b0;
  logic [5:0] cur_node = '0;
  logic [31:0] goal_cell = '0;
  logic [15:0] exp_cnt = '0;
  bit h_mode = 1'b0;

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  int unsigned n_items, n_mism, n_kind [8], cycles;
  int unsigned burst_left = 0, gap_left = 0;

  function automatic logic [23:0] sat_sum(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? COST_MAX : s[23:0];
  endfunction

  function automatic logic [23:0] dist_to_goal(logic [31:0] c);
    int dx, dy;
    if (!h_mode) return '0;
    dx = int'(signed'(c[31:16])) - int'(signed'(goal_cell[31:16]));
    dy = int'(signed'(c[15:0])) - int'(signed'(goal_cell[15:0]));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return 24'(dx + dy);
  endfunction

  task automatic push_result(logic [2:0] k, logic [31:0] c, logic [23:0] t, logic lst);
    out_item_t r;
    r.result_kind = k;
    r.out_x = c[31:16];
    r.out_y = c[15:0];
    r.out_traversal = t[23:16];
    r.out_inputs = t[15:0];
    r.path_last = lst;
    r.expanded_count = exp_cnt;
    expected_q = {expected_q, r};
  endtask

  task automatic pick_next();
    int best;
    int unsigned chain [$];
    int unsigned i;
    best = -1;
    for (int j = 0; j < nd_cnt; j++)
      if (!nd_flg[j][0] && (best < 0 || nd_est[j] < nd_est[best])) best = j;
    if (best < 0) begin
      searching = 1'b0;
      push_result(K_NOPATH, '0, '0, 1'b1);
    end else if (nd_cell[best] == goal_cell) begin
      searching = 1'b0;
      i = best;
      while (nd_flg[i][1] && chain.size() < MAX_NODES_DEF - 1) begin
        chain.push_front(i);
        i = nd_par[i];
      end
      push_result(K_PSTART, nd_cell[i], '0, chain.size() == 0);
      while (chain.size() > 0) begin
        i = chain.pop_front();
        push_result(K_PSTEP, nd_cell[i], nd_tags[i], chain.size() == 0);
      end
    end else begin
      nd_flg[best][0] = 1'b1;
      cur_node = 6'(best);
      if (exp_cnt != 16'hFFFF) exp_cnt++;
      searching = 1'b1;
      push_result(K_EXPAND, nd_cell[best], '0, 1'b1);
    end
  endtask

  task automatic predict_transfer(in_item_t it);
    logic [31:0] c;
    logic [23:0] nxt;
    int hit;
    c = {it.cell_x, it.cell_y};
    if (it.req_type == REQ_START) begin
      goal_cell = {it.goal_x, it.goal_y};
      nd_cnt = 1;
      nd_cell[0] = c;
      nd_cost[0] = '0;
      nd_est[0] = dist_to_goal(c);
      nd_par[0] = '0;
      nd_tags[0] = '0;
      nd_flg[0] = '0;
      cur_node = '0;
      exp_cnt = '0;
      pick_next();
      return;
    end
    if (!searching) return;
    if (it.neighbor_valid) begin
      if (it.edge_cost == '0) begin
        searching = 1'b0;
        push_result(K_BADCST, '0, '0, 1'b1);
        return;
      end
      nxt = sat_sum(nd_cost[cur_node], {8'h0, it.edge_cost});
      hit = -1;
      for (int j = 0; j < nd_cnt; j++)
        if (hit < 0 && nd_cell[j] == c) hit = j;
      if (hit < 0) begin
        if (nd_cnt >= MAX_NODES_DEF) begin
          searching = 1'b0;
          push_result(K_FULL, '0, '0, 1'b1);
          return;
        end
        hit = nd_cnt++;
      end else if (nxt >= nd_cost[hit]) begin
        hit = -1;
      end
      if (hit >= 0) begin
        nd_cell[hit] = c;
        nd_cost[hit] = nxt;
        nd_est[hit] = sat_sum(nxt, dist_to_goal(c));
        nd_par[hit] = cur_node;
        nd_tags[hit] = {it.traversal_tag, it.move_inputs};
        nd_flg[hit] = 2'b10;
      end
      if (!it.last_neighbor) return;
    end
    pick_next();
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
    end else begin
      if (start) predict_transfer(in_item);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_item <= pending_q.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result_valid) begin
      n_kind[result.result_kind]++;
      if (expected_q.size() == 0) begin
        n_mism++;
        if (n_mism <= 10) $display("unexpected result %p", result);
      end else begin
        e = expected_q.pop_front();
        if (result.result_kind !== e.result_kind || result.out_x !== e.out_x ||
            result.out_y !== e.out_y || result.out_traversal !== e.out_traversal ||
            result.out_inputs !== e.out_inputs || result.path_last !== e.path_last ||
            result.expanded_count !== e.expanded_count) begin
          n_mism++;
          if (n_mism <= 10) $display("mismatch: expected %p actual %p", e, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** grid_astar_path_search_top: FAILED **");
      $finish;
    end
  end

  task automatic add_item(logic rq, int x, int y, int gx, int gy, int cost,
                          logic vld, logic lst);
    in_item_t it;
    it.req_type = rq;
    it.cell_x = 16'(x);
    it.cell_y = 16'(y);
    it.goal_x = 16'(gx);
    it.goal_y = 16'(gy);
    it.edge_cost = 16'(cost);
    it.traversal_tag = 8'($urandom);
    it.move_inputs = 16'($urandom);
    it.neighbor_valid = vld;
    it.last_neighbor = lst;
    pending_q = {pending_q, it};
    n_items++;
  endtask

  task automatic add_start(int x, int y, int gx, int gy);
    add_item(REQ_START, x, y, gx, gy, $urandom, 1'($urandom), 1'($urandom));
  endtask

  task automatic add_nb(int x, int y, int cost, logic lst);
    add_item(REQ_NEIGHBOR, x, y, $urandom, $urandom, cost, 1'b1, lst);
  endtask

  // search on a small window, with an occasional zero cost; a wide window fills the table
  task automatic add_search(int span, int lists);
    int bx, by, k, cost;
    bx = $urandom_range(0, 65535);
    by = $urandom_range(0, 65535);
    add_start(bx, by, bx + $urandom_range(0, span), by + $urandom_range(0, span));
    for (int l = 0; l < lists; l++) begin
      if ($urandom_range(0, 11) == 0) begin
        add_item(REQ_NEIGHBOR, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0,
                 1'($urandom));
        continue;
      end
      k = $urandom_range(1, 4);
      for (int j = 0; j < k; j++) begin
        case ($urandom_range(0, 49)) inside
          0: cost = 0;
          1, 2: cost = $urandom_range(1, 65535);
          default: cost = $urandom_range(1, 9);
        endcase
        add_nb(bx + $urandom_range(0, span), by + $urandom_range(0, span), cost, j == k - 1);
      end
    end
  endtask

  task automatic add_noise();
    add_item(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
             1'($urandom), 1'($urandom));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || start || busy || expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    h_mode = m;
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int quota, int span, int lists);
    int unsigned stop;
    stop = n_items + quota;
    while (n_items < stop) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_search(span, $urandom_range(1, lists));
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed, zero heuristic
    add_nb(3, 3, 1, 1'b1);
    add_start(-32768, -32768, -32768, -32768);
    add_start(32767, 32767, -32768, -32768);
    add_start(0, 0, 2, 0);
    add_nb(1, 0, 1, 1'b0);
    add_nb(0, 1, 65535, 1'b1);
    add_nb(2, 0, 1, 1'b1);
    add_start(5, 5, 9, 9);
    add_item(REQ_NEIGHBOR, 6, 6, 0, 0, 1, 1'b0, 1'b0);
    add_start(1, 1, 3, 3);
    add_nb(2, 1, 0, 1'b1);
    add_start(1, 1, 4, 4);
    add_nb(2, 1, 3, 1'b1);
    add_start(7, 7, 7, 7);
    add_start(0, 0, 9, 0);
    add_nb(1, 0, 5, 1'b0);
    add_nb(0, 1, 1, 1'b1);
    add_nb(1, 0, 1, 1'b1);
    add_item(REQ_NEIGHBOR, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    wait_idle();
    set_mode(1'b1);
    add_start(32767, 32767, -32768, -32768);
    add_start(-32768, 32767, 32767, -32768);
    random_phase(130, 4, 10);
    set_mode(1'b0);
    random_phase(120, 3, 10);
    set_mode(1'b1);
    random_phase(120, 40, 40);
    $display("%0d items: %0d expands, %0d path starts, %0d steps, %0d no-path",
             n_items, n_kind[K_EXPAND], n_kind[K_PSTART], n_kind[K_PSTEP], n_kind[K_NOPATH]);
    $display("errors seen: %0d bad cost, %0d table full; heuristic modes 0 and 1",
             n_kind[K_BADCST], n_kind[K_FULL]);
    if (n_mism == 0 && expected_q.size() == 0) begin
      $display("** grid_astar_path_search_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mism, expected_q.size());
      $display("** grid_astar_path_search_top: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/gastar_pkg.sv
rtl/core/gastar_ram.sv
rtl/core/grid_astar_path_search_top.sv
verif/tb_grid_astar_path_search_top.sv
